// File: rtl/plint_pkg.sv
// shared types, widths and codes of the piecewise linear interpolator
package plint_pkg;

  localparam int MAX_POINTS  = 6;
  localparam int TABLE_SLOTS = 6;
  localparam int SEGS        = MAX_POINTS - 1;

  localparam int PT_W       = 16;
  localparam int FRAC_W     = 8;
  localparam int QX_W       = PT_W + FRAC_W;
  localparam int QUOT_W     = PT_W + FRAC_W;
  localparam int PROD_W     = QX_W + PT_W;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2 * PT_W;
  localparam int STATUS_W   = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS = QUOT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam int                   REG_POINT_BASE  = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FEW   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SETUP,
    B_DIV,
    B_FIN
  } back_state_t;

  // one classified query, ready for the arithmetic
  typedef struct packed {
    status_t           status;
    logic [PT_W-1:0]   y0;
    logic [QX_W-1:0]   dq_mag;
    logic [PT_W-1:0]   dy_mag;
    logic              dy_neg;
    logic [PT_W-1:0]   dx_mag;
  } cmd_t;

endpackage

// File: rtl/plint_in_if.sv
// query channel of the interpolator
interface plint_in_if;
  logic                        valid;
  logic                        ready;
  logic [plint_pkg::QX_W-1:0]  query_x;

  modport source (output valid, output query_x, input ready);
  modport sink   (input valid, input query_x, output ready);
endinterface

// File: rtl/plint_out_if.sv
// result channel of the interpolator
interface plint_out_if;
  logic                           valid;
  logic                           ready;
  logic [plint_pkg::QUOT_W-1:0]   result_y;
  logic [plint_pkg::STATUS_W-1:0] status;

  modport source (output valid, output result_y, output status, input ready);
  modport sink   (input valid, input result_y, input status, output ready);
endinterface

// File: rtl/plint_front.sv
// front end: takes a query beat, finds the bracketing segment, forms a command
module plint_front (
  plint_in_if.sink                             query,
  input  logic [plint_pkg::CNT_W-1:0]          point_count,
  input  logic [plint_pkg::CFG_DATA_W-1:0]     points [plint_pkg::TABLE_SLOTS],
  input  logic                                 full,
  output logic                                 push,
  output plint_pkg::cmd_t                      cmd
);

  logic [plint_pkg::CNT_W-1:0] n_eff;
  plint_pkg::cmd_t             seg_cmd [plint_pkg::SEGS];
  logic                        hit     [plint_pkg::SEGS];

  assign query.ready = !full;
  assign push        = query.valid && !full;

  assign n_eff = (point_count > plint_pkg::CNT_W'(plint_pkg::MAX_POINTS)) ?
                 plint_pkg::CNT_W'(plint_pkg::MAX_POINTS) : point_count;

  // every segment is checked at once
  always_comb begin
    for (int i = 0; i < plint_pkg::SEGS; i++) begin
      logic [plint_pkg::PT_W-1:0] x0, x1, y0, y1;
      logic [plint_pkg::QX_W-1:0] xa, xb;
      logic                       up, down;
      x0 = points[i][plint_pkg::PT_W-1:0];
      x1 = points[i+1][plint_pkg::PT_W-1:0];
      y0 = points[i][plint_pkg::CFG_DATA_W-1:plint_pkg::PT_W];
      y1 = points[i+1][plint_pkg::CFG_DATA_W-1:plint_pkg::PT_W];
      xa = {x0, {plint_pkg::FRAC_W{1'b0}}};
      xb = {x1, {plint_pkg::FRAC_W{1'b0}}};
      up   = (query.query_x >= xa) && (query.query_x <= xb);
      down = (query.query_x <= xa) && (query.query_x >= xb);
      hit[i] = (up || down) && (plint_pkg::CNT_W'(i + 1) < n_eff);
      seg_cmd[i].status = plint_pkg::ST_OK;
      seg_cmd[i].y0     = y0;
      seg_cmd[i].dq_mag = (query.query_x >= xa) ? (query.query_x - xa)
                                                : (xa - query.query_x);
      // dq and dx share a sign inside a bracket, so only dy sets the sign
      seg_cmd[i].dy_neg = (y1 < y0);
      seg_cmd[i].dy_mag = (y1 < y0) ? (y0 - y1) : (y1 - y0);
      seg_cmd[i].dx_mag = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    end
  end

  // lowest bracketing segment wins
  always_comb begin
    cmd        = '0;
    cmd.status = (n_eff < plint_pkg::CNT_W'(2)) ? plint_pkg::ST_FEW : plint_pkg::ST_RANGE;
    for (int i = plint_pkg::SEGS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        cmd = seg_cmd[i];
      end
    end
  end

endmodule

// File: rtl/plint_queue.sv
// short command queue between front and back
module plint_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  plint_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output plint_pkg::cmd_t pop_data
);

  plint_pkg::cmd_t                entries [plint_pkg::QUEUE_DEPTH];
  logic [plint_pkg::QPTR_W-1:0]   wr_ptr;
  logic [plint_pkg::QPTR_W-1:0]   rd_ptr;
  logic [plint_pkg::QCNT_W-1:0]   count;

  assign full      = (count == plint_pkg::QCNT_W'(plint_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == plint_pkg::QPTR_W'(plint_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == plint_pkg::QPTR_W'(plint_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/plint_back.sv
// back end: multiply, serial divide, offset and output register
module plint_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  plint_pkg::cmd_t pop_data,
  output logic            pop,
  plint_out_if.source     result
);

  plint_pkg::back_state_t          state, state_next;
  plint_pkg::cmd_t                 job;
  logic [plint_pkg::PROD_W-1:0]    prod;
  logic [plint_pkg::PT_W-1:0]      rem;
  logic [plint_pkg::QUOT_W-1:0]    quot;
  logic [plint_pkg::DCNT_W-1:0]    dcnt;
  logic                            out_valid;
  logic [plint_pkg::QUOT_W-1:0]    out_y;
  plint_pkg::status_t              out_status;

  logic                            load;
  logic                            direct;
  logic [plint_pkg::PT_W:0]        trial;
  logic                            qbit;
  logic [plint_pkg::QUOT_W:0]      base;
  logic [plint_pkg::QUOT_W:0]      sum;
  logic [plint_pkg::QUOT_W-1:0]    y_fin;

  assign result.valid    = out_valid;
  assign result.result_y = out_y;
  assign result.status   = out_status;

  // no divide for an error or a zero-width segment
  assign direct = (pop_data.status != plint_pkg::ST_OK) || (pop_data.dx_mag == '0);

  assign trial = {rem, prod[plint_pkg::QUOT_W-1]};
  assign qbit  = (trial >= {1'b0, job.dx_mag});

  assign base = {1'b0, job.y0, {plint_pkg::FRAC_W{1'b0}}};
  assign sum  = job.dy_neg ? (base - {1'b0, quot}) : (base + {1'b0, quot});

  always_comb begin
    if (job.status != plint_pkg::ST_OK) begin
      y_fin = '0;
    end else if (sum[plint_pkg::QUOT_W]) begin
      y_fin = job.dy_neg ? '0 : '1;
    end else begin
      y_fin = sum[plint_pkg::QUOT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      plint_pkg::B_IDLE: begin
        if (not_empty) begin
          state_next = direct ? plint_pkg::B_FIN : plint_pkg::B_MUL;
        end
      end
      plint_pkg::B_MUL:   state_next = plint_pkg::B_SETUP;
      plint_pkg::B_SETUP: state_next = plint_pkg::B_DIV;
      plint_pkg::B_DIV: begin
        if (dcnt == plint_pkg::DCNT_W'(plint_pkg::DIV_STEPS - 1)) begin
          state_next = plint_pkg::B_FIN;
        end
      end
      plint_pkg::B_FIN: begin
        if (!out_valid || result.ready) begin
          state_next = plint_pkg::B_IDLE;
        end
      end
      default: state_next = plint_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    case (state)
      plint_pkg::B_IDLE: pop  = not_empty;
      plint_pkg::B_FIN:  load = !out_valid || result.ready;
      default: begin
        pop  = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plint_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job  <= pop_data;
      quot <= '0;
    end
    if (state == plint_pkg::B_MUL) begin
      prod <= plint_pkg::PROD_W'(job.dq_mag) * plint_pkg::PROD_W'(job.dy_mag);
    end
    // quotient fits in QUOT_W bits, so the top bits start as the remainder
    if (state == plint_pkg::B_SETUP) begin
      rem  <= prod[plint_pkg::PROD_W-1:plint_pkg::QUOT_W];
      dcnt <= '0;
    end
    if (state == plint_pkg::B_DIV) begin
      rem  <= qbit ? plint_pkg::PT_W'(trial - {1'b0, job.dx_mag})
                   : trial[plint_pkg::PT_W-1:0];
      quot <= {quot[plint_pkg::QUOT_W-2:0], qbit};
      prod <= {prod[plint_pkg::PROD_W-2:0], 1'b0};
      dcnt <= dcnt + 1'b1;
    end
    if (load) begin
      out_y      <= y_fin;
      out_status <= job.status;
    end
  end

endmodule

// File: rtl/piecewise_linear_interpolator.sv
// top level: configuration registers, front end, command queue, back end
//
//   channel  dir  signals                          beat when
//   query    in   valid ready query_x              valid && ready
//   result   out  valid ready result_y status      valid && ready
//   cfg      in   cfg_write cfg_index cfg_data     cfg_write
//
// a query that brackets a segment of nonzero width passes through the back end
// as a pop, one multiply, one setup, 24 restoring divide steps and one offset
// step; error and zero-width queries go from the pop to the offset step. the front end classifies
// in the accept cycle and a two-entry queue lets it take beats while the back end
// divides. reset is synchronous; the result register holds while ready is low.
module piecewise_linear_interpolator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [plint_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plint_pkg::CFG_DATA_W-1:0]     cfg_data,
  plint_in_if.sink                             query,
  plint_out_if.source                          result
);

  logic [plint_pkg::CNT_W-1:0]      point_count;
  logic [plint_pkg::CFG_DATA_W-1:0] points [plint_pkg::TABLE_SLOTS];

  logic            push;
  logic            full;
  logic            pop;
  logic            not_empty;
  plint_pkg::cmd_t push_data;
  plint_pkg::cmd_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= plint_pkg::CNT_W'(2);
      for (int i = 0; i < plint_pkg::TABLE_SLOTS; i++) begin
        points[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == plint_pkg::REG_POINT_COUNT) begin
        point_count <= cfg_data[plint_pkg::CNT_W-1:0];
      end
      for (int i = 0; i < plint_pkg::TABLE_SLOTS; i++) begin
        if (cfg_index == plint_pkg::CFG_IDX_W'(plint_pkg::REG_POINT_BASE + i)) begin
          points[i] <= cfg_data;
        end
      end
    end
  end

  plint_front u_front (
    .query       (query),
    .point_count (point_count),
    .points      (points),
    .full        (full),
    .push        (push),
    .cmd         (push_data)
  );

  plint_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  plint_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );

endmodule
